// File: src/iprc_pkg.sv
package iprc_pkg;

    localparam int ENTRIES_DEF = 4;

    // request modes
    localparam logic [1:0] MODE_ADD   = 2'd0;
    localparam logic [1:0] MODE_WALK  = 2'd1;
    localparam logic [1:0] MODE_FLUSH = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_ADD   = 2'd0;
    localparam logic [1:0] KIND_WALK  = 2'd1;
    localparam logic [1:0] KIND_FLUSH = 2'd2;

    typedef struct packed {
        logic [1:0]  mode;
        logic [31:0] target;
        logic [31:0] netmask;
        logic [31:0] gateway;
    } t_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic        hit;
        logic        evicted;
        logic        entry_valid;
        logic [31:0] out_target;
        logic [31:0] out_netmask;
        logic [31:0] out_gateway;
        logic        last;
    } t_result;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_WALK
    } t_state;

    typedef enum logic [2:0] {
        OP_NONE,
        OP_ADD,
        OP_FLUSH,
        OP_WALK_EMPTY,
        OP_WALK_ENTRY
    } t_op;

    typedef struct packed {
        logic load;
        t_op  op;
    } t_cmd;

    typedef struct packed {
        logic [1:0] mode;
        logic       count_zero;
        logic       walk_last;
    } t_status;

endpackage

// File: src/iprc_ctrl.sv
module iprc_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  iprc_pkg::t_status i_status,
    output logic              o_busy,
    output iprc_pkg::t_cmd    o_cmd
);

    iprc_pkg::t_state r_state;
    iprc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iprc_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.op   = iprc_pkg::OP_NONE;
        o_busy     = 1'b1;
        case (r_state)
            iprc_pkg::S_IDLE: begin
                o_busy = 1'b0;
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = iprc_pkg::S_EXEC;
                end
            end
            iprc_pkg::S_EXEC: begin
                n_state = iprc_pkg::S_IDLE;
                case (i_status.mode)
                    iprc_pkg::MODE_ADD: begin
                        o_cmd.op = iprc_pkg::OP_ADD;
                    end
                    iprc_pkg::MODE_FLUSH: begin
                        o_cmd.op = iprc_pkg::OP_FLUSH;
                    end
                    iprc_pkg::MODE_WALK: begin
                        if (i_status.count_zero) begin
                            o_cmd.op = iprc_pkg::OP_WALK_EMPTY;
                        end else begin
                            o_cmd.op = iprc_pkg::OP_WALK_ENTRY;
                            if (!i_status.walk_last) begin
                                n_state = iprc_pkg::S_WALK;
                            end
                        end
                    end
                    default: begin
                        // unused mode: dropped silently
                        o_cmd.op = iprc_pkg::OP_NONE;
                    end
                endcase
            end
            iprc_pkg::S_WALK: begin
                o_cmd.op = iprc_pkg::OP_WALK_ENTRY;
                if (i_status.walk_last) begin
                    n_state = iprc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = iprc_pkg::S_IDLE;
            end
        endcase
    end

endmodule

// File: src/iprc_dp.sv
module iprc_dp #(
    parameter int ENTRIES = iprc_pkg::ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  iprc_pkg::t_item   i_item,
    input  iprc_pkg::t_cmd    i_cmd,
    output iprc_pkg::t_status o_status,
    output logic              o_strobe,
    output iprc_pkg::t_result o_result
);

    localparam int RW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    iprc_pkg::t_item   r_req;
    logic [31:0]       r_tgt  [ENTRIES];
    logic [31:0]       r_msk  [ENTRIES];
    logic [31:0]       r_gw   [ENTRIES];
    logic [ENTRIES-1:0] r_used;
    logic [RW-1:0]     r_rank [ENTRIES];
    logic [CW-1:0]     r_count;
    logic [RW-1:0]     r_walk;
    logic              r_strobe;
    iprc_pkg::t_result r_res;
    iprc_pkg::t_result n_res;

    logic              hit;
    logic [RW-1:0]     hit_idx;
    logic [RW-1:0]     hit_rank;
    logic              free_found;
    logic [RW-1:0]     free_idx;
    logic [RW-1:0]     old_idx;
    logic [RW-1:0]     ins_idx;
    logic              full;
    logic [31:0]       walk_tgt;
    logic [31:0]       walk_msk;
    logic [31:0]       walk_gw;
    logic [ENTRIES-1:0] rank0_sel;

    // parallel tag match, free search, oldest search, walk word select and newest flags
    always_comb begin
        hit        = 1'b0;
        hit_idx    = '0;
        hit_rank   = '0;
        free_found = 1'b0;
        free_idx   = '0;
        old_idx    = '0;
        walk_tgt   = '0;
        walk_msk   = '0;
        walk_gw    = '0;
        rank0_sel  = '0;
        for (int i = 0; i < ENTRIES; i++) begin
            if (!hit && r_used[i] && r_tgt[i] == r_req.target
                    && r_msk[i] == r_req.netmask) begin
                hit      = 1'b1;
                hit_idx  = RW'(i);
                hit_rank = r_rank[i];
            end
            if (!free_found && !r_used[i]) begin
                free_found = 1'b1;
                free_idx   = RW'(i);
            end
            if (r_used[i] && r_rank[i] == RW'(ENTRIES - 1)) begin
                old_idx = RW'(i);
            end
            if (r_used[i] && r_rank[i] == r_walk) begin
                walk_tgt = walk_tgt | r_tgt[i];
                walk_msk = walk_msk | r_msk[i];
                walk_gw  = walk_gw | r_gw[i];
            end
            rank0_sel[i] = r_used[i] && r_rank[i] == '0;
        end
    end

    assign full    = (r_count == CW'(ENTRIES));
    assign ins_idx = full ? old_idx : free_idx;

    assign o_status.mode       = r_req.mode;
    assign o_status.count_zero = (r_count == '0);
    assign o_status.walk_last  = ((CW'(r_walk) + 1'b1) == r_count);

    always_comb begin
        n_res = '0;
        case (i_cmd.op)
            iprc_pkg::OP_ADD: begin
                n_res.kind    = iprc_pkg::KIND_ADD;
                n_res.hit     = hit;
                n_res.evicted = !hit && full;
                n_res.last    = 1'b1;
            end
            iprc_pkg::OP_FLUSH: begin
                n_res.kind = iprc_pkg::KIND_FLUSH;
                n_res.last = 1'b1;
            end
            iprc_pkg::OP_WALK_EMPTY: begin
                n_res.kind = iprc_pkg::KIND_WALK;
                n_res.last = 1'b1;
            end
            iprc_pkg::OP_WALK_ENTRY: begin
                n_res.kind        = iprc_pkg::KIND_WALK;
                n_res.entry_valid = 1'b1;
                n_res.out_target  = walk_tgt;
                n_res.out_netmask = walk_msk;
                n_res.out_gateway = walk_gw;
                n_res.last        = o_status.walk_last;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // control state: valid bits, recency ranks, fill count, walk pointer, result strobe
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used   <= '0;
            r_rank   <= '{default: '0};
            r_count  <= '0;
            r_walk   <= '0;
            r_strobe <= 1'b0;
        end else begin
            if (i_cmd.load) begin
                r_walk <= '0;
            end
            case (i_cmd.op)
                iprc_pkg::OP_ADD: begin
                    r_strobe <= 1'b1;
                    if (hit) begin
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (RW'(i) == hit_idx) begin
                                r_rank[i] <= '0;
                            end else if (r_used[i] && r_rank[i] < hit_rank) begin
                                r_rank[i] <= r_rank[i] + 1'b1;
                            end
                        end
                    end else begin
                        // new route is newest, every other valid entry ages
                        for (int i = 0; i < ENTRIES; i++) begin
                            if (RW'(i) == ins_idx) begin
                                r_rank[i] <= '0;
                            end else if (r_used[i]) begin
                                r_rank[i] <= r_rank[i] + 1'b1;
                            end
                        end
                        r_used[ins_idx] <= 1'b1;
                        if (!full) begin
                            r_count <= r_count + 1'b1;
                        end
                    end
                end
                iprc_pkg::OP_FLUSH: begin
                    r_strobe <= 1'b1;
                    r_used   <= '0;
                    r_rank   <= '{default: '0};
                    r_count  <= '0;
                end
                iprc_pkg::OP_WALK_EMPTY: begin
                    r_strobe <= 1'b1;
                end
                iprc_pkg::OP_WALK_ENTRY: begin
                    r_strobe <= 1'b1;
                    r_walk   <= r_walk + 1'b1;
                end
                default: begin
                    r_strobe <= 1'b0;
                end
            endcase
        end
    end

    // payload: request, route store, result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_req <= i_item;
        end
        if (i_cmd.op == iprc_pkg::OP_ADD && !hit) begin
            r_tgt[ins_idx] <= r_req.target;
            r_msk[ins_idx] <= r_req.netmask;
            r_gw[ins_idx]  <= r_req.gateway;
        end
        r_res <= n_res;
    end

    assign o_strobe = r_strobe;
    assign o_result = r_res;

    a_count_matches_used: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count == CW'($countones(r_used)))
        else $error("fill count out of step with valid bits");

    a_add_leaves_newest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res.kind == iprc_pkg::KIND_ADD) |-> $onehot(rank0_sel))
        else $error("no single newest entry after add");

    a_evict_only_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res.evicted) |-> (r_count == CW'(ENTRIES)))
        else $error("eviction with free entries left");

    a_walk_valid_vs_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_strobe && r_res.kind == iprc_pkg::KIND_WALK)
            |-> (r_res.entry_valid == (r_count != '0)))
        else $error("walk word validity disagrees with fill count");

endmodule

// File: src/ipv4_route_lru_cache.sv
// Channel   Handshake                 Word
// request   start in, busy out        i_item   (mode, target, netmask, gateway)
// result    o_strobe out, no backoff  o_result (kind, hit, evicted, entry_valid,
//                                               out_target, out_netmask, out_gateway, last)
//
// Add and flush: busy while the sequencer sits in its execute state after the accept edge,
// result strobed in the cycle after that state; a new request is taken once busy drops.
// Walk of n valid entries: one word per cycle from the rank-select mux, busy through the
// execute and walk states up to the last word (one word if n is 0). Mode 3 gives no word.
// Reset (synchronous, active low) leaves every entry free; no clearing pass.
// Results are never held off; busy only reflects the sequencer.
module ipv4_route_lru_cache #(
    parameter int ENTRIES = iprc_pkg::ENTRIES_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    input  iprc_pkg::t_item   i_item,
    output logic              busy,
    output logic              o_strobe,
    output iprc_pkg::t_result o_result
);

    iprc_pkg::t_cmd    cmd;
    iprc_pkg::t_status status;

    iprc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_status (status),
        .o_busy   (busy),
        .o_cmd    (cmd)
    );

    iprc_dp #(
        .ENTRIES (ENTRIES)
    ) u_dp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (cmd),
        .o_status (status),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

endmodule
